@@ rtl/three_level_ready_queue_scheduler_unit_assert.svh @@
// Assertion helpers for the ready-queue scheduler.
`ifndef THREE_LEVEL_READY_QUEUE_SCHEDULER_UNIT_ASSERT_SVH
`define THREE_LEVEL_READY_QUEUE_SCHEDULER_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define TLRQ_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define TLRQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/tlrq_pkg.sv @@
package tlrq_pkg;

    localparam int SLOTS  = 32;
    localparam int SLOT_W = $clog2(SLOTS);
    localparam int CNT_W  = $clog2(SLOTS + 1);
    localparam int TICK_W = 32;

    localparam logic [7:0]  PRIO_MAX  = 8'd149;
    localparam logic [7:0]  BAND1_MIN = 8'd100;
    localparam logic [7:0]  BAND2_MIN = 8'd50;
    localparam logic [15:0] THR_RST   = 16'd1500;
    localparam logic [5:0]  STEP_RST  = 6'd10;
    localparam logic [7:0]  CAP_RST   = 8'd149;

    // level indexes (level one is the shortest-burst queue)
    localparam logic [1:0] LVL_ONE   = 2'd0;
    localparam logic [1:0] LVL_TWO   = 2'd1;
    localparam logic [1:0] LVL_THREE = 2'd2;

    localparam logic [1:0] CFG_THRESHOLD = 2'd0;
    localparam logic [1:0] CFG_STEP      = 2'd1;
    localparam logic [1:0] CFG_CAP       = 2'd2;

    typedef enum logic [1:0] {
        KIND_ENQ = 2'd0,
        KIND_DEQ = 2'd1,
        KIND_AGE = 2'd2
    } t_kind;

    typedef enum logic [3:0] {
        ST_IDLE, ST_ENQ, ST_LINK_INIT, ST_LINK, ST_PREEMPT, ST_DEQ,
        ST_SNAP, ST_AGE_RD, ST_UNLINK, ST_AGE_OUT, ST_FIN
    } t_state;

    typedef struct packed {
        logic [1:0]        kind;
        logic [7:0]        thread_id;
        logic [7:0]        priority_req;
        logic [31:0]       predicted_burst;
        logic [TICK_W-1:0] run_total;
        logic [TICK_W-1:0] wait_mark;
        logic              first_entry;
        logic              from_running;
        logic [TICK_W-1:0] now_ticks;
        logic              running_valid;
        logic [7:0]        running_priority;
        logic [31:0]       running_burst;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  out_thread;
        logic        out_valid;
        logic [1:0]  out_level;
        logic [7:0]  new_priority;
        logic [31:0] new_wait_mark;
        logic        preempt_request;
        logic        store_full;
        logic        last;
    } t_out_item;

    typedef struct packed {
        logic [7:0]        thread;
        logic [7:0]        prio;
        logic [31:0]       burst;
        logic [TICK_W-1:0] run;
        logic [TICK_W-1:0] mark;
        logic [SLOT_W-1:0] nxt;
    } t_entry;

    typedef struct packed {
        logic              fld_en;
        logic              prio_en;
        logic              mark_en;
        logic [SLOT_W-1:0] addr;
        logic [7:0]        thread;
        logic [7:0]        prio;
        logic [31:0]       burst;
        logic [TICK_W-1:0] run;
        logic [TICK_W-1:0] mark;
        logic              nx0_en;
        logic [SLOT_W-1:0] nx0_addr;
        logic [SLOT_W-1:0] nx0_data;
        logic              nx1_en;
        logic [SLOT_W-1:0] nx1_addr;
        logic [SLOT_W-1:0] nx1_data;
    } t_st_wr;

    typedef struct packed {
        logic [7:0]        thread;
        logic              valid;
        logic [1:0]        level;
        logic [7:0]        prio;
        logic [TICK_W-1:0] mark;
        logic              full;
    } t_res;

    function automatic logic [7:0] clamp_prio(input logic [7:0] p);
        return (p > PRIO_MAX) ? PRIO_MAX : p;
    endfunction

    function automatic logic [1:0] band_of(input logic [7:0] p);
        return (p >= BAND1_MIN) ? LVL_ONE : ((p >= BAND2_MIN) ? LVL_TWO : LVL_THREE);
    endfunction

endpackage

@@ rtl/tlrq_in_if.sv @@
interface tlrq_in_if;
    logic               valid;
    logic               ready;
    tlrq_pkg::t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ rtl/tlrq_out_if.sv @@
interface tlrq_out_if;
    logic                valid;
    logic                ready;
    tlrq_pkg::t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ rtl/tlrq_store.sv @@
module tlrq_store (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [tlrq_pkg::SLOT_W-1:0]    i_raddr,
    output tlrq_pkg::t_entry               o_rdata,
    input  tlrq_pkg::t_st_wr               i_wr
);
    logic [7:0]                    r_thread [tlrq_pkg::SLOTS];
    logic [7:0]                    r_prio   [tlrq_pkg::SLOTS];
    logic [31:0]                   r_burst  [tlrq_pkg::SLOTS];
    logic [tlrq_pkg::TICK_W-1:0]   r_run    [tlrq_pkg::SLOTS];
    logic [tlrq_pkg::TICK_W-1:0]   r_mark   [tlrq_pkg::SLOTS];
    logic [tlrq_pkg::SLOT_W-1:0]   r_next   [tlrq_pkg::SLOTS];

    always_ff @(posedge i_clk) begin
        if (i_wr.fld_en) begin
            r_thread[i_wr.addr] <= i_wr.thread;
            r_burst[i_wr.addr]  <= i_wr.burst;
            r_run[i_wr.addr]    <= i_wr.run;
        end
        if (i_wr.prio_en) begin
            r_prio[i_wr.addr] <= i_wr.prio;
        end
        if (i_wr.mark_en) begin
            r_mark[i_wr.addr] <= i_wr.mark;
        end
    end

    // link field: free chain in slot order after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < tlrq_pkg::SLOTS; i++) begin
                r_next[i] <= tlrq_pkg::SLOT_W'(i + 1);
            end
        end else begin
            if (i_wr.nx0_en) begin
                r_next[i_wr.nx0_addr] <= i_wr.nx0_data;
            end
            if (i_wr.nx1_en) begin
                r_next[i_wr.nx1_addr] <= i_wr.nx1_data;
            end
        end
    end

    assign o_rdata = '{thread: r_thread[i_raddr], prio: r_prio[i_raddr],
                       burst: r_burst[i_raddr], run: r_run[i_raddr],
                       mark: r_mark[i_raddr], nxt: r_next[i_raddr]};
endmodule

@@ rtl/three_level_ready_queue_scheduler_unit.sv @@
// The next item is accepted only after the current one finishes: a dequeue reads one
// head, an enqueue walks its level to the insert point (or ends at once when full), and an
// aging tick snapshots every queue, then unlinks and refiles each aged entry of levels
// two and three. Result stalls hold the block.
// Reset (synchronous, active low): queues empty, free chain in slot order,
// registers to 1500/10/149, no pending preemption; no clearing pass.
module three_level_ready_queue_scheduler_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    tlrq_in_if.sink           i_item,
    tlrq_out_if.source        o_res,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_idx,
    input  logic [15:0]       i_cfg_wdata
);
    localparam int SW = tlrq_pkg::SLOT_W;
    localparam int CW = tlrq_pkg::CNT_W;
    localparam int TW = tlrq_pkg::TICK_W;

    tlrq_pkg::t_state   r_state, n_state;
    logic [SW-1:0]      r_head [3];
    logic [SW-1:0]      n_head [3];
    logic [CW-1:0]      r_count [3];
    logic [CW-1:0]      n_count [3];
    logic [SW-1:0]      r_free, n_free;
    logic               r_preempt, n_preempt;
    logic [15:0]        r_thr;
    logic [5:0]         r_step;
    logic [7:0]         r_cap;
    tlrq_pkg::t_in_item r_item, n_item;
    logic [SW-1:0]      r_s, n_s, r_cur, n_cur, r_prev, n_prev;
    logic               r_hasprev, n_hasprev;
    logic [CW-1:0]      r_walk, n_walk, r_cnt, n_cnt, r_ai, n_ai;
    logic [1:0]         r_lv, n_lv, r_nl, n_nl, r_slv, n_slv;
    logic               r_ret_age, n_ret_age;
    logic [7:0]         r_key_prio, n_key_prio;
    logic [31:0]        r_key_burst, n_key_burst;
    logic [SW-1:0]      r_order [tlrq_pkg::SLOTS];
    logic [1:0]         r_olv [tlrq_pkg::SLOTS];
    logic               ord_we;
    tlrq_pkg::t_res     r_hold, n_hold, r_res, n_res;
    logic               r_hold_v, n_hold_v;
    logic               r_ov, n_ov;
    tlrq_pkg::t_out_item r_out, n_out;

    logic [SW-1:0]      raddr;
    tlrq_pkg::t_entry   rd;
    tlrq_pkg::t_st_wr   wr;
    logic               push, push_last;
    tlrq_pkg::t_res     push_res;
    logic               out_free;
    logic [CW:0]        total;

    // shared walk/arithmetic terms
    logic               goes_first, walk_end;
    logic [TW-1:0]      wait_t;
    logic               ages;
    logic [8:0]         sum;
    logic [8:0]         np;
    logic [7:0]         ep, rp;
    logic [1:0]         dlv, rl;
    logic               dfound, pre_c;
    logic [TW-1:0]      enq_mark;
    logic [SW-1:0]      age_slot;
    logic [1:0]         age_lv;

    tlrq_store u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_raddr (raddr),
        .o_rdata (rd),
        .i_wr    (wr)
    );

    assign out_free     = !r_ov || o_res.ready;
    assign total        = (CW+1)'(r_count[0]) + (CW+1)'(r_count[1]) + (CW+1)'(r_count[2]);
    assign i_item.ready = (r_state == tlrq_pkg::ST_IDLE);
    assign o_res.valid  = r_ov;
    assign o_res.data   = r_out;

    assign age_slot = r_order[r_ai[SW-1:0]];
    assign age_lv   = r_olv[r_ai[SW-1:0]];
    assign ep       = tlrq_pkg::clamp_prio(r_item.priority_req);
    assign enq_mark = r_item.first_entry ? r_item.now_ticks : r_item.wait_mark;
    assign rp       = tlrq_pkg::clamp_prio(r_item.running_priority);
    assign rl       = tlrq_pkg::band_of(rp);

    always_comb begin
        dfound = 1'b1;
        dlv    = tlrq_pkg::LVL_ONE;
        if (r_count[0] != '0) begin
            dlv = tlrq_pkg::LVL_ONE;
        end else if (r_count[1] != '0) begin
            dlv = tlrq_pkg::LVL_TWO;
        end else if (r_count[2] != '0) begin
            dlv = tlrq_pkg::LVL_THREE;
        end else begin
            dfound = 1'b0;
        end
    end

    // compare unit of the link walk: tie goes after existing entries
    always_comb begin
        case (r_lv)
            tlrq_pkg::LVL_ONE: goes_first = r_key_burst < rd.burst;
            tlrq_pkg::LVL_TWO: goes_first = r_key_prio > rd.prio;
            default:           goes_first = 1'b0;
        endcase
    end
    assign walk_end = (r_walk == r_count[r_lv]);

    // aging arithmetic on the entry under the read port
    assign wait_t = r_item.now_ticks - rd.run - rd.mark;
    assign ages   = !wait_t[TW-1] && (wait_t > TW'(r_thr));
    assign sum    = {1'b0, rd.prio} + 9'(r_step);
    always_comb begin
        np = sum;
        if (age_lv == tlrq_pkg::LVL_ONE) begin
            if (np > {1'b0, r_cap}) np = {1'b0, r_cap};
            if (np < {1'b0, rd.prio}) np = {1'b0, rd.prio};
        end else if (sum >= {1'b0, tlrq_pkg::BAND1_MIN}) begin
            if (np > {1'b0, r_cap}) np = {1'b0, r_cap};
            if (np < {1'b0, tlrq_pkg::BAND1_MIN}) np = {1'b0, tlrq_pkg::BAND1_MIN};
        end
    end

    always_comb begin
        case (rl)
            tlrq_pkg::LVL_THREE: pre_c = (r_count[0] != '0) || (r_count[1] != '0);
            tlrq_pkg::LVL_TWO:   pre_c = (r_count[0] != '0);
            default:  pre_c = (r_count[0] != '0) && (rd.burst < r_item.running_burst);
        endcase
    end

    always_comb begin
        n_state = r_state;
        n_head = r_head;
        n_count = r_count;
        n_free = r_free;
        n_preempt = r_preempt;
        n_item = r_item;
        n_s = r_s;
        n_cur = r_cur;
        n_prev = r_prev;
        n_hasprev = r_hasprev;
        n_walk = r_walk;
        n_cnt = r_cnt;
        n_ai = r_ai;
        n_lv = r_lv;
        n_nl = r_nl;
        n_slv = r_slv;
        n_ret_age = r_ret_age;
        n_key_prio = r_key_prio;
        n_key_burst = r_key_burst;
        n_hold = r_hold;
        n_hold_v = r_hold_v;
        n_res = r_res;
        wr = '0;
        ord_we = 1'b0;
        raddr = r_cur;
        push = 1'b0;
        push_last = 1'b0;
        push_res = r_hold;

        case (r_state)
            tlrq_pkg::ST_IDLE: begin
                if (i_item.valid) begin
                    n_item = i_item.data;
                    case (tlrq_pkg::t_kind'(i_item.data.kind))
                        tlrq_pkg::KIND_ENQ: n_state = tlrq_pkg::ST_ENQ;
                        tlrq_pkg::KIND_DEQ: n_state = tlrq_pkg::ST_DEQ;
                        tlrq_pkg::KIND_AGE: begin
                            n_slv = tlrq_pkg::LVL_THREE;
                            n_cur = r_head[tlrq_pkg::LVL_THREE];
                            n_walk = '0;
                            n_cnt = '0;
                            n_state = tlrq_pkg::ST_SNAP;
                        end
                        default: begin
                            n_hold = '0;
                            n_hold_v = 1'b1;
                            n_state = tlrq_pkg::ST_FIN;
                        end
                    endcase
                end
            end
            tlrq_pkg::ST_ENQ: begin
                raddr = r_free;
                n_hold = '0;
                n_hold_v = 1'b1;
                if (total >= (CW+1)'(tlrq_pkg::SLOTS)) begin
                    n_hold.full = 1'b1;
                    n_state = tlrq_pkg::ST_FIN;
                end else begin
                    wr.fld_en = 1'b1;
                    wr.prio_en = 1'b1;
                    wr.mark_en = 1'b1;
                    wr.addr = r_free;
                    wr.thread = r_item.thread_id;
                    wr.prio = ep;
                    wr.burst = r_item.predicted_burst;
                    wr.run = r_item.run_total;
                    wr.mark = enq_mark;
                    n_free = rd.nxt;
                    n_s = r_free;
                    n_lv = tlrq_pkg::band_of(ep);
                    n_key_prio = ep;
                    n_key_burst = r_item.predicted_burst;
                    n_ret_age = 1'b0;
                    n_hold = '{thread: r_item.thread_id, valid: 1'b1,
                               level: tlrq_pkg::band_of(ep) + 2'd1, prio: ep,
                               mark: enq_mark, full: 1'b0};
                    n_state = tlrq_pkg::ST_LINK_INIT;
                end
            end
            tlrq_pkg::ST_LINK_INIT: begin
                n_cur = r_head[r_lv];
                n_walk = '0;
                n_hasprev = 1'b0;
                n_state = r_ret_age ? tlrq_pkg::ST_LINK : tlrq_pkg::ST_LINK;
            end
            tlrq_pkg::ST_LINK: begin
                raddr = r_cur;
                if (walk_end || goes_first) begin
                    wr.nx0_en = 1'b1;
                    wr.nx0_addr = r_s;
                    wr.nx0_data = r_cur;
                    if (r_hasprev) begin
                        wr.nx1_en = 1'b1;
                        wr.nx1_addr = r_prev;
                        wr.nx1_data = r_s;
                    end else begin
                        n_head[r_lv] = r_s;
                    end
                    n_count[r_lv] = r_count[r_lv] + CW'(1);
                    n_state = r_ret_age ? tlrq_pkg::ST_AGE_OUT : tlrq_pkg::ST_PREEMPT;
                end else begin
                    n_prev = r_cur;
                    n_hasprev = 1'b1;
                    n_cur = rd.nxt;
                    n_walk = r_walk + CW'(1);
                end
            end
            tlrq_pkg::ST_PREEMPT: begin
                raddr = r_head[tlrq_pkg::LVL_ONE];
                if (!r_item.from_running && r_item.running_valid && pre_c) begin
                    n_preempt = 1'b1;
                end
                n_state = tlrq_pkg::ST_FIN;
            end
            tlrq_pkg::ST_DEQ: begin
                raddr = r_head[dlv];
                n_preempt = 1'b0;
                n_hold = '0;
                n_hold_v = 1'b1;
                if (dfound) begin
                    n_head[dlv] = rd.nxt;
                    n_count[dlv] = r_count[dlv] - CW'(1);
                    wr.nx0_en = 1'b1;
                    wr.nx0_addr = r_head[dlv];
                    wr.nx0_data = r_free;
                    n_free = r_head[dlv];
                    n_hold = '{thread: rd.thread, valid: 1'b1, level: dlv + 2'd1,
                               prio: rd.prio, mark: rd.mark, full: 1'b0};
                end
                n_state = tlrq_pkg::ST_FIN;
            end
            tlrq_pkg::ST_SNAP: begin
                // record queue order as it stands at the start of the tick
                raddr = r_cur;
                if (r_walk == r_count[r_slv]) begin
                    if (r_slv == tlrq_pkg::LVL_ONE) begin
                        n_ai = '0;
                        n_state = tlrq_pkg::ST_AGE_RD;
                    end else begin
                        n_slv = r_slv - 2'd1;
                        n_cur = r_head[r_slv - 2'd1];
                        n_walk = '0;
                    end
                end else begin
                    ord_we = 1'b1;
                    n_cnt = r_cnt + CW'(1);
                    n_cur = rd.nxt;
                    n_walk = r_walk + CW'(1);
                end
            end
            tlrq_pkg::ST_AGE_RD: begin
                raddr = age_slot;
                if (r_ai == r_cnt) begin
                    n_state = tlrq_pkg::ST_FIN;
                end else if (!ages) begin
                    n_ai = r_ai + CW'(1);
                end else begin
                    wr.prio_en = 1'b1;
                    wr.mark_en = 1'b1;
                    wr.addr = age_slot;
                    wr.prio = np[7:0];
                    wr.mark = rd.mark + wait_t;
                    n_s = age_slot;
                    n_res = '{thread: rd.thread, valid: 1'b1, level: 2'd1,
                              prio: np[7:0], mark: rd.mark + wait_t, full: 1'b0};
                    if (age_lv == tlrq_pkg::LVL_ONE) begin
                        n_state = tlrq_pkg::ST_AGE_OUT;
                    end else begin
                        n_res.level = tlrq_pkg::band_of(np[7:0]) + 2'd1;
                        n_key_prio = np[7:0];
                        n_key_burst = rd.burst;
                        n_nl = tlrq_pkg::band_of(np[7:0]);
                        n_lv = age_lv;
                        n_cur = r_head[age_lv];
                        n_walk = '0;
                        n_hasprev = 1'b0;
                        n_ret_age = 1'b1;
                        n_state = tlrq_pkg::ST_UNLINK;
                    end
                end
            end
            tlrq_pkg::ST_UNLINK: begin
                raddr = r_cur;
                if (walk_end) begin
                    n_lv = r_nl;
                    n_state = tlrq_pkg::ST_LINK_INIT;
                end else if (r_cur == r_s) begin
                    if (r_hasprev) begin
                        wr.nx0_en = 1'b1;
                        wr.nx0_addr = r_prev;
                        wr.nx0_data = rd.nxt;
                    end else begin
                        n_head[r_lv] = rd.nxt;
                    end
                    n_count[r_lv] = r_count[r_lv] - CW'(1);
                    n_lv = r_nl;
                    n_state = tlrq_pkg::ST_LINK_INIT;
                end else begin
                    n_prev = r_cur;
                    n_hasprev = 1'b1;
                    n_cur = rd.nxt;
                    n_walk = r_walk + CW'(1);
                end
            end
            tlrq_pkg::ST_AGE_OUT: begin
                // hold one result back so the final beat can carry last
                if (!r_hold_v || out_free) begin
                    push = r_hold_v;
                    n_hold = r_res;
                    n_hold_v = 1'b1;
                    n_ai = r_ai + CW'(1);
                    n_state = tlrq_pkg::ST_AGE_RD;
                end
            end
            tlrq_pkg::ST_FIN: begin
                if (out_free) begin
                    push = 1'b1;
                    push_last = 1'b1;
                    push_res = r_hold_v ? r_hold : '0;
                    n_hold_v = 1'b0;
                    n_state = tlrq_pkg::ST_IDLE;
                end
            end
            default: n_state = tlrq_pkg::ST_IDLE;
        endcase

        n_ov = r_ov;
        n_out = r_out;
        if (push) begin
            n_ov = 1'b1;
            n_out = '{out_thread: push_res.thread, out_valid: push_res.valid,
                      out_level: push_res.level, new_priority: push_res.prio,
                      new_wait_mark: push_res.mark[31:0], preempt_request: n_preempt,
                      store_full: push_res.full, last: push_last};
        end else if (o_res.ready) begin
            n_ov = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= tlrq_pkg::ST_IDLE;
            r_head    <= '{default: '0};
            r_count   <= '{default: '0};
            r_free    <= '0;
            r_preempt <= 1'b0;
            r_hold_v  <= 1'b0;
            r_ov      <= 1'b0;
            r_thr     <= tlrq_pkg::THR_RST;
            r_step    <= tlrq_pkg::STEP_RST;
            r_cap     <= tlrq_pkg::CAP_RST;
        end else begin
            r_state   <= n_state;
            r_head    <= n_head;
            r_count   <= n_count;
            r_free    <= n_free;
            r_preempt <= n_preempt;
            r_hold_v  <= n_hold_v;
            r_ov      <= n_ov;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    tlrq_pkg::CFG_THRESHOLD: r_thr <= i_cfg_wdata;
                    tlrq_pkg::CFG_STEP:      r_step <= i_cfg_wdata[5:0];
                    tlrq_pkg::CFG_CAP:       r_cap <= i_cfg_wdata[7:0];
                    default: ;
                endcase
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_item      <= n_item;
        r_s         <= n_s;
        r_cur       <= n_cur;
        r_prev      <= n_prev;
        r_hasprev   <= n_hasprev;
        r_walk      <= n_walk;
        r_cnt       <= n_cnt;
        r_ai        <= n_ai;
        r_lv        <= n_lv;
        r_nl        <= n_nl;
        r_slv       <= n_slv;
        r_ret_age   <= n_ret_age;
        r_key_prio  <= n_key_prio;
        r_key_burst <= n_key_burst;
        r_hold      <= n_hold;
        r_res       <= n_res;
        r_out       <= n_out;
        if (ord_we) begin
            r_order[r_cnt[SW-1:0]] <= r_cur;
            r_olv[r_cnt[SW-1:0]]   <= r_slv;
        end
    end

`include "three_level_ready_queue_scheduler_unit_assert.svh"

    `TLRQ_ASSERT_NOW(a_total_bound, 1'b1, total <= (CW+1)'(tlrq_pkg::SLOTS), "queue total over store size")
    `TLRQ_ASSERT_NEXT(a_busy_after_accept, i_item.valid && i_item.ready, !i_item.ready, "ready after accept")
    `TLRQ_ASSERT_NEXT(a_last_ends_item, push && push_last, r_state == tlrq_pkg::ST_IDLE, "last beat without idle")
    `TLRQ_ASSERT_NOW(a_no_lost_beat, push, out_free, "result pushed over a waiting beat")

endmodule

@@ tb/three_level_ready_queue_scheduler_unit_tb.sv @@
module three_level_ready_queue_scheduler_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // A kind code the block has to ignore.
    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 1000000;
    // Worst aging walk: every entry walked twice per aged entry.
    localparam int SETTLE_CYCLES = 2200;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [15:0] i_cfg_wdata;

    tlrq_in_if  item_if ();
    tlrq_out_if res_if ();

    three_level_ready_queue_scheduler_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (item_if.sink),
        .o_res       (res_if.source),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // ------------------------------------------------------------------
    // Scheduler shadow: one entry store holding three linked ready queues.
    // ------------------------------------------------------------------
    logic [7:0]  sh_thread [tlrq_pkg::SLOTS];
    logic [7:0]  sh_prio   [tlrq_pkg::SLOTS];
    logic [31:0] sh_burst  [tlrq_pkg::SLOTS];
    logic [31:0] sh_run    [tlrq_pkg::SLOTS];
    logic [31:0] sh_mark   [tlrq_pkg::SLOTS];
    logic [4:0]  sh_next   [tlrq_pkg::SLOTS];
    logic [4:0]  sh_head   [3];
    int          sh_count  [3];
    logic [4:0]  sh_free;
    bit          sh_pending;
    logic [15:0] sh_threshold;
    logic [5:0]  sh_step;
    logic [7:0]  sh_cap;

    tlrq_pkg::t_out_item pending_results[$];
    int          error_count;
    int          cycle_count;
    logic [31:0] tick_now;

    function automatic logic [7:0] limit_prio(input logic [7:0] p);
        return (p > tlrq_pkg::PRIO_MAX) ? tlrq_pkg::PRIO_MAX : p;
    endfunction

    // Map a priority to its queue: 0 is level one, 2 is level three.
    function automatic int level_for(input int p);
        return (p >= 100) ? 0 : ((p >= 50) ? 1 : 2);
    endfunction

    // Level one sorts on shortest burst, level two on highest priority;
    // ties stay behind entries already queued.
    function automatic bit sorts_ahead(input int lv, input int s, input int cur);
        if (lv == 0) return sh_burst[s] < sh_burst[cur];
        if (lv == 1) return sh_prio[s] > sh_prio[cur];
        return 1'b0;
    endfunction

    function automatic void file_slot(input int lv, input int s);
        int cur;
        int prev;
        bit has_prev;
        cur = sh_head[lv];
        prev = 0;
        has_prev = 0;
        for (int i = 0; i < sh_count[lv]; i++) begin
            if (sorts_ahead(lv, s, cur)) break;
            prev = cur;
            has_prev = 1;
            cur = sh_next[cur];
        end
        sh_next[s] = 5'(cur);
        if (has_prev) sh_next[prev] = 5'(s);
        else sh_head[lv] = 5'(s);
        sh_count[lv]++;
    endfunction

    function automatic void pull_slot(input int lv, input int s);
        int cur;
        int prev;
        bit has_prev;
        cur = sh_head[lv];
        prev = 0;
        has_prev = 0;
        for (int i = 0; i < sh_count[lv]; i++) begin
            if (cur == s) begin
                if (has_prev) sh_next[prev] = sh_next[cur];
                else sh_head[lv] = sh_next[cur];
                sh_count[lv]--;
                return;
            end
            prev = cur;
            has_prev = 1;
            cur = sh_next[cur];
        end
    endfunction

    function automatic tlrq_pkg::t_out_item entry_beat(input int s, input int lv);
        tlrq_pkg::t_out_item r;
        r = '0;
        r.out_thread    = sh_thread[s];
        r.out_valid     = 1'b1;
        r.out_level     = 2'(lv + 1);
        r.new_priority  = sh_prio[s];
        r.new_wait_mark = sh_mark[s];
        return r;
    endfunction

    function automatic void shadow_reset();
        for (int i = 0; i < tlrq_pkg::SLOTS; i++) sh_next[i] = 5'(i + 1);
        for (int i = 0; i < 3; i++) begin
            sh_head[i] = '0;
            sh_count[i] = 0;
        end
        sh_free = '0;
        sh_pending = 0;
        sh_threshold = tlrq_pkg::THR_RST;
        sh_step = tlrq_pkg::STEP_RST;
        sh_cap = tlrq_pkg::CAP_RST;
    endfunction

    // Advance the shadow by one accepted item and queue the beats it causes.
    function automatic void schedule_item(input tlrq_pkg::t_in_item it);
        tlrq_pkg::t_out_item beats[$];
        tlrq_pkg::t_out_item r;
        int s;
        int lv;
        int rl;
        int np;
        int old;
        int nl;
        bit hit;
        int order_slot[$];
        int order_lv[$];
        int cur;
        logic [31:0] w;
        case (it.kind)
            tlrq_pkg::KIND_ENQ: begin
                if (sh_count[0] + sh_count[1] + sh_count[2] >= tlrq_pkg::SLOTS) begin
                    r = '0;
                    r.store_full = 1'b1;
                    beats.push_back(r);
                end else begin
                    s = sh_free;
                    lv = level_for(limit_prio(it.priority_req));
                    sh_free = sh_next[s];
                    sh_thread[s] = it.thread_id;
                    sh_prio[s]   = limit_prio(it.priority_req);
                    sh_burst[s]  = it.predicted_burst;
                    sh_run[s]    = it.run_total;
                    sh_mark[s]   = it.first_entry ? it.now_ticks : it.wait_mark;
                    file_slot(lv, s);
                    if (!it.from_running && it.running_valid) begin
                        rl = level_for(limit_prio(it.running_priority));
                        if (rl == 2) hit = sh_count[0] != 0 || sh_count[1] != 0;
                        else if (rl == 1) hit = sh_count[0] != 0;
                        else hit = sh_count[0] != 0 &&
                                   sh_burst[sh_head[0]] < it.running_burst;
                        if (hit) sh_pending = 1;
                    end
                    beats.push_back(entry_beat(s, lv));
                end
            end
            tlrq_pkg::KIND_DEQ: begin
                sh_pending = 0;
                r = '0;
                for (int l = 0; l < 3; l++) begin
                    if (sh_count[l] != 0) begin
                        s = sh_head[l];
                        sh_head[l] = sh_next[s];
                        sh_count[l]--;
                        r = entry_beat(s, l);
                        sh_next[s] = sh_free;
                        sh_free = 5'(s);
                        break;
                    end
                end
                beats.push_back(r);
            end
            tlrq_pkg::KIND_AGE: begin
                // Snapshot the walk order first: level three, two, then one.
                for (int li = 2; li >= 0; li--) begin
                    cur = sh_head[li];
                    for (int j = 0; j < sh_count[li]; j++) begin
                        order_slot.push_back(cur);
                        order_lv.push_back(li);
                        cur = sh_next[cur];
                    end
                end
                foreach (order_slot[i]) begin
                    if (beats.size() >= 32) break;
                    s = order_slot[i];
                    lv = order_lv[i];
                    old = sh_prio[s];
                    w = it.now_ticks - sh_run[s] - sh_mark[s];
                    if (w[31] || w <= {16'd0, sh_threshold}) continue;
                    sh_mark[s] = sh_mark[s] + w;
                    np = old + sh_step;
                    if (lv == 0) begin
                        if (np > sh_cap) np = sh_cap;
                        if (np < old) np = old;
                        sh_prio[s] = 8'(np);
                        nl = 0;
                    end else begin
                        if (np >= 100) begin
                            if (np > sh_cap) np = sh_cap;
                            if (np < 100) np = 100;
                        end
                        pull_slot(lv, s);
                        sh_prio[s] = 8'(np);
                        nl = level_for(np);
                        file_slot(nl, s);
                    end
                    beats.push_back(entry_beat(s, nl));
                end
                if (beats.size() == 0) beats.push_back('0);
            end
            default: beats.push_back('0);
        endcase
        foreach (beats[k]) begin
            beats[k].preempt_request = sh_pending;
            beats[k].last = (k == beats.size() - 1);
            pending_results.push_back(beats[k]);
        end
    endfunction

    // ------------------------------------------------------------------
    // Clock, cycle count and watchdog.
    // ------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) cycle_count <= cycle_count + 1;

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("TEST FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // Result side: stall on a randomly drawn mode, and check
    // each beat against the oldest queued expectation.
    // ------------------------------------------------------------------
    int stall_mode;

    always @(posedge i_clk) begin
        tlrq_pkg::t_out_item want;
        tlrq_pkg::t_out_item got;
        if (cycle_count % 64 == 0) stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            0: res_if.ready <= 1'b1;
            1: res_if.ready <= 1'($urandom_range(0, 1));
            2: res_if.ready <= ($urandom_range(0, 3) == 0);
            default: res_if.ready <= ($urandom_range(0, 15) > 12);
        endcase
        if (i_rst_n && res_if.valid && res_if.ready) begin
            got = res_if.data;
            if (pending_results.size() == 0) begin
                $error("unexpected result beat, thread %0d", got.out_thread);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (got.out_thread !== want.out_thread) begin
                    $error("out_thread: expected %0d actual %0d",
                           want.out_thread, got.out_thread);
                    error_count++;
                end
                if (got.out_valid !== want.out_valid) begin
                    $error("out_valid: expected %0d actual %0d",
                           want.out_valid, got.out_valid);
                    error_count++;
                end
                if (got.out_level !== want.out_level) begin
                    $error("out_level: expected %0d actual %0d",
                           want.out_level, got.out_level);
                    error_count++;
                end
                if (got.new_priority !== want.new_priority) begin
                    $error("new_priority: expected %0d actual %0d",
                           want.new_priority, got.new_priority);
                    error_count++;
                end
                if (got.new_wait_mark !== want.new_wait_mark) begin
                    $error("new_wait_mark: expected %0h actual %0h",
                           want.new_wait_mark, got.new_wait_mark);
                    error_count++;
                end
                if (got.preempt_request !== want.preempt_request) begin
                    $error("preempt_request: expected %0d actual %0d",
                           want.preempt_request, got.preempt_request);
                    error_count++;
                end
                if (got.store_full !== want.store_full) begin
                    $error("store_full: expected %0d actual %0d",
                           want.store_full, got.store_full);
                    error_count++;
                end
                if (got.last !== want.last) begin
                    $error("last: expected %0d actual %0d", want.last, got.last);
                    error_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Sender helpers.
    // ------------------------------------------------------------------
    // Hold valid and the beat until the block takes it; valid stays high
    // so a following call keeps the burst going without a gap.
    task automatic send_item(input tlrq_pkg::t_in_item it);
        item_if.valid <= 1'b1;
        item_if.data  <= it;
        @(posedge i_clk);
        while (!item_if.ready) @(posedge i_clk);
        schedule_item(it);
    endtask

    task automatic hold_off(input int cycles);
        item_if.valid <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    // Drop valid and wait until every queued result has come out, then let
    // the block settle before anything that needs it idle.
    task automatic drain();
        item_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_regs(input logic [15:0] thr, input logic [5:0] step,
                              input logic [7:0] cap);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_idx <= tlrq_pkg::CFG_THRESHOLD;
        i_cfg_wdata <= thr;
        @(posedge i_clk);
        sh_threshold = thr;
        i_cfg_idx <= tlrq_pkg::CFG_STEP;
        i_cfg_wdata <= {10'd0, step};
        @(posedge i_clk);
        sh_step = step;
        i_cfg_idx <= tlrq_pkg::CFG_CAP;
        i_cfg_wdata <= {8'd0, cap};
        @(posedge i_clk);
        sh_cap = cap;
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic tlrq_pkg::t_in_item enq_item(input logic [7:0] id,
                                                    input logic [7:0] prio,
                                                    input logic [31:0] burst);
        tlrq_pkg::t_in_item it;
        it = '0;
        it.kind = tlrq_pkg::KIND_ENQ;
        it.thread_id = id;
        it.priority_req = prio;
        it.predicted_burst = burst;
        it.now_ticks = tick_now;
        it.wait_mark = tick_now;
        return it;
    endfunction

    function automatic tlrq_pkg::t_in_item bare_item(input logic [1:0] kind);
        tlrq_pkg::t_in_item it;
        it = '0;
        it.kind = kind;
        it.now_ticks = tick_now;
        return it;
    endfunction

    // Random item: mostly realistic tick values so that aging fires, with
    // some fully random fields so every bit toggles.
    function automatic tlrq_pkg::t_in_item random_item();
        tlrq_pkg::t_in_item it;
        int pick;
        pick = $urandom_range(0, 99);
        it.kind = (pick < 50) ? tlrq_pkg::KIND_ENQ : (pick < 75) ? tlrq_pkg::KIND_DEQ :
                  (pick < 95) ? tlrq_pkg::KIND_AGE : KIND_UNUSED;
        it.thread_id = 8'($urandom);
        it.priority_req = ($urandom_range(0, 9) == 0) ? 8'($urandom) :
                          8'($urandom_range(0, 149));
        it.predicted_burst = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 16);
        it.first_entry = 1'($urandom_range(0, 1));
        it.from_running = 1'($urandom_range(0, 1));
        it.running_valid = 1'($urandom_range(0, 1));
        it.running_priority = ($urandom_range(0, 9) == 0) ? 8'($urandom) :
                              8'($urandom_range(0, 149));
        it.running_burst = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 16);
        if ($urandom_range(0, 9) == 0) begin
            it.run_total = $urandom;
            it.wait_mark = $urandom;
            it.now_ticks = $urandom;
        end else begin
            tick_now = tick_now + $urandom_range(0, 900);
            it.run_total = $urandom_range(0, 300);
            it.wait_mark = tick_now - $urandom_range(0, 400);
            it.now_ticks = tick_now;
        end
        return it;
    endfunction

    // ------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------
    task automatic test_bands_and_preempt();
        tlrq_pkg::t_in_item it;
        send_item(bare_item(tlrq_pkg::KIND_DEQ));  // dequeue on empty store
        send_item(bare_item(tlrq_pkg::KIND_AGE));  // tick with nothing to age
        send_item(bare_item(KIND_UNUSED));         // ignored kind
        send_item(enq_item(8'd1, 8'd0, 32'd5));
        send_item(enq_item(8'd2, 8'd49, 32'd5));
        send_item(enq_item(8'd3, 8'd50, 32'd5));
        send_item(enq_item(8'd4, 8'd99, 32'd5));
        send_item(enq_item(8'd5, 8'd99, 32'd5));   // priority tie in level two
        send_item(enq_item(8'd6, 8'd100, 32'd9));
        send_item(enq_item(8'd7, 8'd149, 32'd3));
        send_item(enq_item(8'd8, 8'd200, 32'd3));  // burst tie, priority above range
        it = enq_item(8'hff, 8'hff, 32'hffff_ffff);
        it.first_entry = 1'b1;
        it.run_total = 32'hffff_ffff;
        it.wait_mark = 32'hffff_ffff;
        it.running_valid = 1'b1;
        it.running_priority = 8'hff;               // running in level one, longer burst
        it.running_burst = 32'hffff_ffff;
        send_item(it);
        send_item(bare_item(tlrq_pkg::KIND_DEQ));  // clears pending preemption
        it = enq_item(8'd9, 8'd10, 32'd1);
        it.running_valid = 1'b1;
        it.running_priority = 8'd20;               // running in level three
        send_item(it);
        it.running_priority = 8'd70;               // running in level two
        send_item(it);
        it.from_running = 1'b1;
        send_item(it);
        repeat (13) send_item(bare_item(tlrq_pkg::KIND_DEQ));
        drain();
    endtask

    task automatic test_store_full();
        for (int i = 0; i < tlrq_pkg::SLOTS + 2; i++)
            send_item(enq_item(8'(i), 8'($urandom_range(0, 149)), $urandom_range(0, 8)));
        hold_off(3);
        for (int i = 0; i < tlrq_pkg::SLOTS + 1; i++)
            send_item(bare_item(tlrq_pkg::KIND_DEQ));
        drain();
    endtask

    task automatic test_aging(input logic [15:0] thr, input logic [5:0] step,
                              input logic [7:0] cap);
        tlrq_pkg::t_in_item it;
        write_regs(thr, step, cap);
        for (int i = 0; i < 6; i++) begin
            it = enq_item(8'(8'h40 + i), 8'($urandom_range(0, 149)), $urandom_range(0, 8));
            it.run_total = $urandom_range(0, 50);
            send_item(it);
        end
        for (int i = 0; i < 3; i++) begin
            tick_now = tick_now + $urandom_range(0, 3000);
            send_item(bare_item(tlrq_pkg::KIND_AGE));
        end
        for (int i = 0; i < 6; i++) send_item(bare_item(tlrq_pkg::KIND_DEQ));
        drain();
    endtask

    task automatic test_random(input int items);
        int burst_len;
        int sent;
        sent = 0;
        while (sent < items) begin
            burst_len = $urandom_range(1, 10);
            for (int b = 0; b < burst_len && sent < items; b++) begin
                send_item(random_item());
                sent++;
            end
            if (sent % 60 < burst_len) drain();    // wait for the pipe to empty
            else if ($urandom_range(0, 3) != 0) hold_off($urandom_range(1, 6));
        end
        drain();
    endtask

    initial begin
        tick_now = 32'd1000;
        shadow_reset();
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_idx <= tlrq_pkg::CFG_THRESHOLD;
        i_cfg_wdata <= '0;
        item_if.valid <= 1'b0;
        item_if.data <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_bands_and_preempt();
        test_store_full();
        test_aging(16'd0, 6'd63, 8'd149);
        test_aging(16'd0, 6'd63, 8'd0);
        test_aging(16'hffff, 6'd0, 8'd120);
        test_aging(16'd200, 6'd40, 8'd100);
        write_regs(tlrq_pkg::THR_RST, tlrq_pkg::STEP_RST, tlrq_pkg::CAP_RST);
        test_random(20);
        write_regs(16'd300, 6'd25, 8'd130);
        test_random(20);

        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (error_count == 0 && pending_results.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

@@ three_level_ready_queue_scheduler_unit.f @@
+incdir+rtl
rtl/tlrq_pkg.sv
rtl/tlrq_in_if.sv
rtl/tlrq_out_if.sv
rtl/tlrq_store.sv
rtl/three_level_ready_queue_scheduler_unit.sv
tb/three_level_ready_queue_scheduler_unit_tb.sv
